/* rtl/dot_flip_scheduler_top_assert.svh */
// assertion macros for the checker file dfs_checker.sv
`ifndef DOT_FLIP_SCHEDULER_TOP_ASSERT_SVH
`define DOT_FLIP_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define DFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dot flip scheduler check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define DFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dot flip scheduler check failed");

`endif

/* rtl/dfs_pkg.sv */
`default_nettype none

package dfs_pkg;

    localparam int ROWS  = 28;
    localparam int COLS  = 28;
    localparam int DOTS  = ROWS * COLS;
    localparam int IDX_W = (DOTS > 1) ? $clog2(DOTS) : 1;
    localparam int CNT_W = $clog2(DOTS + 1);
    localparam int POS_W = 5;

    // reciprocal split of a sweep position into its two coordinates
    localparam int RCP_SH  = 16;
    localparam int RCP_W   = RCP_SH + 1;
    localparam int ROW_RCP = (2 ** RCP_SH + ROWS - 1) / ROWS;
    localparam int COL_RCP = (2 ** RCP_SH + COLS - 1) / COLS;
    localparam int PROD_W  = CNT_W + RCP_W;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_NEXT = 2'd1;
    localparam logic [1:0] FUNC_SET  = 2'd2;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic             data;
    } t_wr_req;

    function automatic logic [IDX_W-1:0] dot_index(input logic [POS_W-1:0] r,
                                                   input logic [POS_W-1:0] c);
        dot_index = IDX_W'(r) * IDX_W'(COLS) + IDX_W'(c);
    endfunction

    // divide by 7 for a 5-bit index below 28
    function automatic logic [1:0] grp7(input logic [POS_W-1:0] v);
        if (v >= POS_W'(21)) begin
            grp7 = 2'd3;
        end else if (v >= POS_W'(14)) begin
            grp7 = 2'd2;
        end else if (v >= POS_W'(7)) begin
            grp7 = 2'd1;
        end else begin
            grp7 = 2'd0;
        end
    endfunction

    // (v mod 7) + 1 + 8 * val, the mod-plus-one never exceeds 7 for an index below 28
    function automatic logic [3:0] code7(input logic [POS_W-1:0] v, input logic val);
        logic [POS_W-1:0] rem;
        rem   = v - POS_W'(7) * POS_W'(grp7(v));
        code7 = {val, 3'(rem + POS_W'(1))};
    endfunction

endpackage

`default_nettype wire

/* rtl/dfs_frame_mem.sv */
`default_nettype none

module dfs_frame_mem (
    input  wire                        i_clk,
    input  wire dfs_pkg::t_wr_req      i_tgt_wr,
    input  wire dfs_pkg::t_wr_req      i_shw_wr,
    input  wire                        i_rd_en,
    input  wire [dfs_pkg::IDX_W-1:0]   i_rd_addr,
    output logic                       o_tgt_q,
    output logic                       o_shw_q
);

    logic r_tgt_mem [dfs_pkg::DOTS];
    logic r_shw_mem [dfs_pkg::DOTS];
    logic r_tgt_q;
    logic r_shw_q;

    // target frame
    always_ff @(posedge i_clk) begin
        if (i_tgt_wr.we) begin
            r_tgt_mem[i_tgt_wr.addr] <= i_tgt_wr.data;
        end
        if (i_rd_en) begin
            r_tgt_q <= r_tgt_mem[i_rd_addr];
        end
    end

    // shown frame
    always_ff @(posedge i_clk) begin
        if (i_shw_wr.we) begin
            r_shw_mem[i_shw_wr.addr] <= i_shw_wr.data;
        end
        if (i_rd_en) begin
            r_shw_q <= r_shw_mem[i_rd_addr];
        end
    end

    assign o_tgt_q = r_tgt_q;
    assign o_shw_q = r_shw_q;

endmodule

`default_nettype wire

/* rtl/dot_flip_scheduler_top.sv */
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+----------------------------------------
// command   | in        | i_start & !o_busy    | i_func, i_row, i_col, i_pixel_value
// result    | out       | o_res_strobe (1 cyc) | o_flip_valid, o_row_group, o_row_code,
//           |           |                      | o_col_group, o_col_code, o_dot_value,
//           |           |                      | o_done_res
// config    | in        | i_cfg_we             | i_cfg_wdata (sweep order)
//
// after reset both frame memories are cleared one dot per cycle while the block is busy
// loads and direct sets can come back to back; a direct set reports the next cycle
// a next request splits the cursor by a reciprocal multiply and scans one dot per cycle
// through the single read port: the quotient is registered, the conversion state sets row
// and column, and each scan step compares the dot read before; an empty sweep ends in done
// the receiver cannot stall; each result strobe lasts exactly one cycle
`default_nettype none

module dot_flip_scheduler_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire [1:0]   i_func,
    input  wire [4:0]   i_row,
    input  wire [4:0]   i_col,
    input  wire         i_pixel_value,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    output logic        o_res_strobe,
    output logic        o_flip_valid,
    output logic [1:0]  o_row_group,
    output logic [3:0]  o_row_code,
    output logic [1:0]  o_col_group,
    output logic [3:0]  o_col_code,
    output logic        o_dot_value,
    output logic        o_done_res
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_CONV  = 4'b0100,
        ST_SCAN  = 4'b1000
    } t_state;

    localparam int IDX_W  = dfs_pkg::IDX_W;
    localparam int CNT_W  = dfs_pkg::CNT_W;
    localparam int POS_W  = dfs_pkg::POS_W;
    localparam int RCP_W  = dfs_pkg::RCP_W;
    localparam int PROD_W = dfs_pkg::PROD_W;

    // control state
    t_state             r_state,     n_state;
    logic               r_sweep_order;
    logic [CNT_W-1:0]   r_cursor,    n_cursor;
    logic [IDX_W-1:0]   r_clr_cnt,   n_clr_cnt;
    logic               r_chk_vld,   n_chk_vld;
    logic               r_res_strobe, n_res_strobe;

    // working registers of the cursor split and the scan
    logic [POS_W-1:0]   r_quo,       n_quo;
    logic [CNT_W-1:0]   r_pos,       n_pos;
    logic [POS_W-1:0]   r_row,       n_row;
    logic [POS_W-1:0]   r_col,       n_col;
    logic [CNT_W-1:0]   r_chk_pos,   n_chk_pos;
    logic [POS_W-1:0]   r_chk_row,   n_chk_row;
    logic [POS_W-1:0]   r_chk_col,   n_chk_col;

    // result payload
    logic               r_flip_valid, n_flip_valid;
    logic [1:0]         r_row_group,  n_row_group;
    logic [3:0]         r_row_code,   n_row_code;
    logic [1:0]         r_col_group,  n_col_group;
    logic [3:0]         r_col_code,   n_col_code;
    logic               r_dot_value,  n_dot_value;
    logic               r_done_res,   n_done_res;

    dfs_pkg::t_wr_req   w_tgt_wr;
    dfs_pkg::t_wr_req   w_shw_wr;
    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_tgt_q;
    logic               w_shw_q;

    logic               w_acc;
    logic               w_in_rng;
    logic [CNT_W-1:0]   w_div;
    logic [RCP_W-1:0]   w_recip;
    logic [PROD_W-1:0]  w_prod;
    logic [CNT_W-1:0]   w_rem;
    logic               w_more;
    logic               w_hit;

    dfs_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_tgt_wr  (w_tgt_wr),
        .i_shw_wr  (w_shw_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_tgt_q   (w_tgt_q),
        .o_shw_q   (w_shw_q)
    );

    assign w_acc    = i_start && (r_state == ST_IDLE);
    assign w_in_rng = (i_row < POS_W'(dfs_pkg::ROWS)) && (i_col < POS_W'(dfs_pkg::COLS));
    // column-major walks down a column, so the cursor splits by the row count
    assign w_div    = r_sweep_order ? CNT_W'(dfs_pkg::ROWS) : CNT_W'(dfs_pkg::COLS);
    assign w_recip  = r_sweep_order ? RCP_W'(dfs_pkg::ROW_RCP) : RCP_W'(dfs_pkg::COL_RCP);
    // quotient by reciprocal multiply, exact over the whole cursor range
    assign w_prod   = PROD_W'(r_cursor) * PROD_W'(w_recip);
    assign w_rem    = r_cursor - CNT_W'(r_quo) * w_div;
    // positions still left to issue in this sweep
    assign w_more   = (r_pos < CNT_W'(dfs_pkg::DOTS));
    // the dot read last cycle differs between target and shown
    assign w_hit    = r_chk_vld && (w_tgt_q != w_shw_q);
    assign w_rd_en  = (r_state == ST_SCAN) && w_more;
    assign w_rd_addr = dfs_pkg::dot_index(r_row, r_col);

    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_clr_cnt    = r_clr_cnt;
        n_chk_vld    = r_chk_vld;
        n_res_strobe = 1'b0;
        n_quo        = r_quo;
        n_pos        = r_pos;
        n_row        = r_row;
        n_col        = r_col;
        n_chk_pos    = r_chk_pos;
        n_chk_row    = r_chk_row;
        n_chk_col    = r_chk_col;
        n_flip_valid = r_flip_valid;
        n_row_group  = r_row_group;
        n_row_code   = r_row_code;
        n_col_group  = r_col_group;
        n_col_code   = r_col_code;
        n_dot_value  = r_dot_value;
        n_done_res   = r_done_res;
        w_tgt_wr     = '0;
        w_shw_wr     = '0;

        case (r_state)
            ST_CLEAR: begin
                // both frames start blank
                w_tgt_wr = '{we: 1'b1, addr: r_clr_cnt, data: 1'b0};
                w_shw_wr = '{we: 1'b1, addr: r_clr_cnt, data: 1'b0};
                if (r_clr_cnt == IDX_W'(dfs_pkg::DOTS - 1)) begin
                    n_clr_cnt = '0;
                    n_state   = ST_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_func)
                        dfs_pkg::FUNC_LOAD: begin
                            if (w_in_rng) begin
                                w_tgt_wr = '{we: 1'b1, addr: dfs_pkg::dot_index(i_row, i_col),
                                             data: i_pixel_value};
                            end
                        end
                        dfs_pkg::FUNC_SET: begin
                            // driven even when the dot already shows the value
                            if (w_in_rng) begin
                                w_shw_wr = '{we: 1'b1, addr: dfs_pkg::dot_index(i_row, i_col),
                                             data: i_pixel_value};
                                n_res_strobe = 1'b1;
                                n_flip_valid = 1'b1;
                                n_row_group  = dfs_pkg::grp7(i_row);
                                n_row_code   = dfs_pkg::code7(i_row, i_pixel_value);
                                n_col_group  = dfs_pkg::grp7(i_col);
                                n_col_code   = dfs_pkg::code7(i_col, i_pixel_value);
                                n_dot_value  = i_pixel_value;
                                n_done_res   = 1'b0;
                            end
                        end
                        dfs_pkg::FUNC_NEXT: begin
                            n_quo   = w_prod[dfs_pkg::RCP_SH +: POS_W];
                            n_state = ST_CONV;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CONV: begin
                // cursor position to row and column in the current order
                if (r_sweep_order) begin
                    n_col = r_quo;
                    n_row = POS_W'(w_rem);
                end else begin
                    n_row = r_quo;
                    n_col = POS_W'(w_rem);
                end
                n_pos     = r_cursor;
                n_chk_vld = 1'b0;
                n_state   = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_hit) begin
                    // flip the found dot, cursor goes just past it
                    w_shw_wr = '{we: 1'b1, addr: dfs_pkg::dot_index(r_chk_row, r_chk_col),
                                 data: w_tgt_q};
                    n_cursor     = r_chk_pos + CNT_W'(1);
                    n_chk_vld    = 1'b0;
                    n_res_strobe = 1'b1;
                    n_flip_valid = 1'b1;
                    n_row_group  = dfs_pkg::grp7(r_chk_row);
                    n_row_code   = dfs_pkg::code7(r_chk_row, w_tgt_q);
                    n_col_group  = dfs_pkg::grp7(r_chk_col);
                    n_col_code   = dfs_pkg::code7(r_chk_col, w_tgt_q);
                    n_dot_value  = w_tgt_q;
                    n_done_res   = 1'b0;
                    n_state      = ST_IDLE;
                end else if (!r_chk_vld && !w_more) begin
                    // sweep exhausted, rewind
                    n_cursor     = '0;
                    n_res_strobe = 1'b1;
                    n_flip_valid = 1'b0;
                    n_row_group  = '0;
                    n_row_code   = '0;
                    n_col_group  = '0;
                    n_col_code   = '0;
                    n_dot_value  = 1'b0;
                    n_done_res   = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_chk_vld = w_more;
                    if (w_more) begin
                        n_chk_pos = r_pos;
                        n_chk_row = r_row;
                        n_chk_col = r_col;
                        n_pos     = r_pos + CNT_W'(1);
                        if (r_sweep_order) begin
                            if (r_row == POS_W'(dfs_pkg::ROWS - 1)) begin
                                n_row = '0;
                                n_col = r_col + POS_W'(1);
                            end else begin
                                n_row = r_row + POS_W'(1);
                            end
                        end else begin
                            if (r_col == POS_W'(dfs_pkg::COLS - 1)) begin
                                n_col = '0;
                                n_row = r_row + POS_W'(1);
                            end else begin
                                n_col = r_col + POS_W'(1);
                            end
                        end
                    end
                end
            end
            default: begin
                n_state   = ST_CLEAR;
                n_clr_cnt = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_sweep_order <= 1'b0;
            r_cursor      <= '0;
            r_clr_cnt     <= '0;
            r_chk_vld     <= 1'b0;
            r_res_strobe  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cursor     <= n_cursor;
            r_clr_cnt    <= n_clr_cnt;
            r_chk_vld    <= n_chk_vld;
            r_res_strobe <= n_res_strobe;
            if (i_cfg_we) begin
                r_sweep_order <= i_cfg_wdata;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_quo        <= n_quo;
        r_pos        <= n_pos;
        r_row        <= n_row;
        r_col        <= n_col;
        r_chk_pos    <= n_chk_pos;
        r_chk_row    <= n_chk_row;
        r_chk_col    <= n_chk_col;
        r_flip_valid <= n_flip_valid;
        r_row_group  <= n_row_group;
        r_row_code   <= n_row_code;
        r_col_group  <= n_col_group;
        r_col_code   <= n_col_code;
        r_dot_value  <= n_dot_value;
        r_done_res   <= n_done_res;
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_res_strobe = r_res_strobe;
    assign o_flip_valid = r_flip_valid;
    assign o_row_group  = r_row_group;
    assign o_row_code   = r_row_code;
    assign o_col_group  = r_col_group;
    assign o_col_code   = r_col_code;
    assign o_dot_value  = r_dot_value;
    assign o_done_res   = r_done_res;

endmodule

`default_nettype wire

/* rtl/dfs_checker.sv */
`default_nettype none

`include "dot_flip_scheduler_top_assert.svh"

module dfs_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire         o_busy,
    input  wire [1:0]   i_func,
    input  wire [4:0]   i_row,
    input  wire [4:0]   i_col,
    input  wire         i_pixel_value,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    input  wire         o_res_strobe,
    input  wire         o_flip_valid,
    input  wire [1:0]   o_row_group,
    input  wire [3:0]   o_row_code,
    input  wire [1:0]   o_col_group,
    input  wire [3:0]   o_col_code,
    input  wire         o_dot_value,
    input  wire         o_done_res
);

    logic w_set_acc;
    logic w_res_flip;
    logic w_done_blank;
    logic w_flip_form;

    assign w_set_acc = i_start && !o_busy && (i_func == dfs_pkg::FUNC_SET) &&
                       (i_row < 5'(dfs_pkg::ROWS)) && (i_col < 5'(dfs_pkg::COLS));
    assign w_res_flip   = o_res_strobe && o_flip_valid;
    assign w_done_blank = (o_row_group == 2'd0) && (o_row_code == 4'd0) &&
                          (o_col_group == 2'd0) && (o_col_code == 4'd0) && !o_dot_value;
    assign w_flip_form  = (o_row_code[3] == o_dot_value) && (o_col_code[3] == o_dot_value) &&
                          (o_row_code[2:0] != 3'd0) && (o_col_code[2:0] != 3'd0);

    // a result is either a flip or a done, never both or neither
    `DFS_ASSERT_IMP(a_res_kind, o_res_strobe, o_flip_valid != o_done_res)

    // done result carries no command
    `DFS_ASSERT_IMP(a_done_zero, o_res_strobe && o_done_res, w_done_blank)

    // codes of a flip carry the value in the top bit and a nonzero position
    `DFS_ASSERT_IMP(a_flip_code, w_res_flip, w_flip_form)

    // a direct set in range is answered in the next cycle with its value
    `DFS_ASSERT_NXT(a_set_resp, w_set_acc, w_res_flip && (o_dot_value == $past(i_pixel_value)))

endmodule

bind dot_flip_scheduler_top dfs_checker u_dfs_checker (.*);

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

    // func code that the block does not decode
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // hang limit, set well above the slowest correct run (full sweeps, long gaps)
    localparam int RUN_LIMIT   = 3_000_000;
    // a load has no result; leave SETTLE_CYCS idle cycles before a config write
    localparam int SETTLE_CYCS = 4;
    // a direct set reports in the cycle after it is taken, an empty sweep when its scan ends
    localparam int TAIL_CYCS   = 40;

    // one command toward the block; drain marks a pause until all flips have come back
    typedef struct {
        logic [1:0] func;
        logic [4:0] row;
        logic [4:0] col;
        logic       pix;
        bit         drain;
    } t_dot_cmd;

    // one drive command or done report, laid out as the result ports
    typedef struct packed {
        logic       flip_valid;
        logic [1:0] row_group;
        logic [3:0] row_code;
        logic [1:0] col_group;
        logic [3:0] col_code;
        logic       dot_value;
        logic       done_res;
    } t_flip_res;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_start       = 1'b0;
    logic [1:0] i_func        = dfs_pkg::FUNC_LOAD;
    logic [4:0] i_row         = '0;
    logic [4:0] i_col         = '0;
    logic       i_pixel_value = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic       i_cfg_wdata   = 1'b0;
    logic       o_busy;
    logic       o_res_strobe;
    logic       o_flip_valid;
    logic [1:0] o_row_group;
    logic [3:0] o_row_code;
    logic [1:0] o_col_group;
    logic [3:0] o_col_code;
    logic       o_dot_value;
    logic       o_done_res;

    dot_flip_scheduler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_func        (i_func),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_pixel_value (i_pixel_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_res_strobe  (o_res_strobe),
        .o_flip_valid  (o_flip_valid),
        .o_row_group   (o_row_group),
        .o_row_code    (o_row_code),
        .o_col_group   (o_col_group),
        .o_col_code    (o_col_code),
        .o_dot_value   (o_dot_value),
        .o_done_res    (o_done_res)
    );

    // commands waiting to be offered, and flips the block still owes us
    t_dot_cmd  pend_cmds[$];
    t_flip_res flips_due[$];

    // our own copy of the panel state
    bit shown_dots[dfs_pkg::DOTS];
    bit target_dots[dfs_pkg::DOTS];
    int scan_pos    = 0;
    bit col_major   = 1'b0;

    int issued_cnt   = 0;
    int accepted_cnt = 0;
    int counted_cmds = 0;
    int hold_cnt     = 0;
    int calm_left    = 0;
    int cycle_cnt    = 0;
    int fault_cnt    = 0;

    t_dot_cmd  drv_cmd;
    t_flip_res seen_res;
    t_flip_res due_res;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // drive command for one dot: group is index / 7, code is index mod 7 + 1, top bit the value
    function automatic t_flip_res make_flip(input int r, input int c, input bit v);
        t_flip_res f;
        f            = '0;
        f.flip_valid = 1'b1;
        f.row_group  = 2'(r / 7);
        f.row_code   = {v, 3'(r % 7 + 1)};
        f.col_group  = 2'(c / 7);
        f.col_code   = {v, 3'(c % 7 + 1)};
        f.dot_value  = v;
        return f;
    endfunction

    // update the panel copy for one taken command and queue the result it causes, if any
    task automatic predict_cmd(input logic [1:0] f, input logic [4:0] r, input logic [4:0] c,
                               input logic v);
        t_flip_res res;
        int        p;
        int        r_i;
        int        c_i;
        int        idx;
        bit        hit;
        case (f)
            dfs_pkg::FUNC_LOAD: begin
                if (r < dfs_pkg::ROWS && c < dfs_pkg::COLS)
                    target_dots[r * dfs_pkg::COLS + c] = v;
            end
            dfs_pkg::FUNC_SET: begin
                // direct set always drives, target untouched
                if (r < dfs_pkg::ROWS && c < dfs_pkg::COLS) begin
                    shown_dots[r * dfs_pkg::COLS + c] = v;
                    flips_due.push_back(make_flip(r, c, v));
                end
            end
            dfs_pkg::FUNC_NEXT: begin
                hit = 1'b0;
                // sweep from the cursor to the end of the order, no wrap
                for (p = scan_pos; p < dfs_pkg::DOTS && !hit; p++) begin
                    if (col_major) begin
                        c_i = p / dfs_pkg::ROWS;
                        r_i = p % dfs_pkg::ROWS;
                    end else begin
                        r_i = p / dfs_pkg::COLS;
                        c_i = p % dfs_pkg::COLS;
                    end
                    idx = r_i * dfs_pkg::COLS + c_i;
                    if (target_dots[idx] != shown_dots[idx]) begin
                        shown_dots[idx] = target_dots[idx];
                        scan_pos        = p + 1;
                        flips_due.push_back(make_flip(r_i, c_i, target_dots[idx]));
                        hit             = 1'b1;
                    end
                end
                // nothing left: report done and rewind
                if (!hit) begin
                    scan_pos     = 0;
                    res          = '0;
                    res.done_res = 1'b1;
                    flips_due.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_cnt++;
        end
    endtask

    // queue one command; ignored ones (bad func, load or set off the panel) are not counted
    task automatic push_cmd(input logic [1:0] f, input int r, input int c, input bit v);
        t_dot_cmd cmd;
        cmd.func  = f;
        cmd.row   = 5'(r);
        cmd.col   = 5'(c);
        cmd.pix   = v;
        cmd.drain = 1'b0;
        pend_cmds.push_back(cmd);
        if (!(f == FUNC_NONE ||
              (f != dfs_pkg::FUNC_NEXT && (r >= dfs_pkg::ROWS || c >= dfs_pkg::COLS))))
            counted_cmds++;
    endtask

    // mostly back to back, some short gaps, a few long ones, now and then a calm stretch
    function automatic int pick_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // wait until no command is pending and every flip is back
    task automatic wait_quiet();
        while (pend_cmds.size() != 0 || issued_cnt != accepted_cnt || flips_due.size() != 0
               || o_busy)
            @(negedge i_clk);
    endtask

    // sweep order is only changed while the block is idle
    task automatic set_order(input bit v);
        wait_quiet();
        repeat (SETTLE_CYCS) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // random traffic: mostly load bursts followed by enough next requests to drain them
    task automatic queue_random(input int n);
        int       goal;
        int       roll;
        int       k;
        int       m;
        int       i;
        t_dot_cmd pause;
        goal = counted_cmds + n;
        while (counted_cmds < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                k = $urandom_range(1, 8);
                for (i = 0; i < k; i++)
                    push_cmd(dfs_pkg::FUNC_LOAD, $urandom_range(0, dfs_pkg::ROWS - 1),
                             $urandom_range(0, dfs_pkg::COLS - 1), $urandom_range(0, 1));
                m = k + $urandom_range(0, 2);
                for (i = 0; i < m; i++) begin
                    if ($urandom_range(0, 7) == 0)
                        push_cmd(dfs_pkg::FUNC_SET, $urandom_range(0, dfs_pkg::ROWS - 1),
                                 $urandom_range(0, dfs_pkg::COLS - 1), $urandom_range(0, 1));
                    push_cmd(dfs_pkg::FUNC_NEXT, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 1));
                end
            end else if (roll < 80) begin
                push_cmd(dfs_pkg::FUNC_SET, $urandom_range(0, dfs_pkg::ROWS - 1),
                         $urandom_range(0, dfs_pkg::COLS - 1), $urandom_range(0, 1));
            end else if (roll < 84) begin
                // hold the sender until all flips are back
                pause       = '{dfs_pkg::FUNC_LOAD, 5'd0, 5'd0, 1'b0, 1'b1};
                pend_cmds.push_back(pause);
            end else begin
                // noise: any func, any dot including off-panel ones
                push_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 1));
            end
        end
    endtask

    // driver: offers the head of the queue at the falling edge, holds it until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (issued_cnt != accepted_cnt) begin
            // offered item not taken yet, keep it on the ports
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_start <= 1'b0;
        end else if (pend_cmds.size() == 0) begin
            i_start <= 1'b0;
        end else if (pend_cmds[0].drain) begin
            i_start <= 1'b0;
            if (flips_due.size() == 0) void'(pend_cmds.pop_front());
        end else begin
            drv_cmd       = pend_cmds.pop_front();
            i_func        <= drv_cmd.func;
            i_row         <= drv_cmd.row;
            i_col         <= drv_cmd.col;
            i_pixel_value <= drv_cmd.pix;
            i_start       <= 1'b1;
            issued_cnt++;
            hold_cnt      = pick_gap();
        end
    end

    // monitor: check results first, then predict for the item taken at this edge
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (i_rst_n) begin
            if (o_res_strobe) begin
                seen_res = '{o_flip_valid, o_row_group, o_row_code, o_col_group, o_col_code,
                             o_dot_value, o_done_res};
                if (flips_due.size() == 0) begin
                    $error("result with nothing expected: %h", seen_res);
                    fault_cnt++;
                end else begin
                    due_res = flips_due.pop_front();
                    cmp_field("flip_valid", due_res.flip_valid, seen_res.flip_valid);
                    cmp_field("row_group", due_res.row_group, seen_res.row_group);
                    cmp_field("row_code", due_res.row_code, seen_res.row_code);
                    cmp_field("col_group", due_res.col_group, seen_res.col_group);
                    cmp_field("col_code", due_res.col_code, seen_res.col_code);
                    cmp_field("dot_value", due_res.dot_value, seen_res.dot_value);
                    cmp_field("done_res", due_res.done_res, seen_res.done_res);
                end
            end
            if (i_cfg_we) col_major = i_cfg_wdata;
            if (i_start && !o_busy) begin
                predict_cmd(i_func, i_row, i_col, i_pixel_value);
                accepted_cnt++;
            end
        end
        // hang guard
        if (cycle_cnt > RUN_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        // reset once, then the block clears its frames while busy
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, row-major: empty sweep, corners, off-panel and unknown func ignored
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);
        push_cmd(dfs_pkg::FUNC_LOAD, 0, 0, 1);
        push_cmd(dfs_pkg::FUNC_LOAD, 27, 27, 1);
        push_cmd(dfs_pkg::FUNC_LOAD, 31, 5, 1);
        push_cmd(dfs_pkg::FUNC_LOAD, 5, 31, 1);
        push_cmd(FUNC_NONE, 31, 31, 1);
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);
        push_cmd(dfs_pkg::FUNC_NEXT, 31, 31, 1);
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);
        // direct sets, one onto a dot already showing the value, two off the panel
        push_cmd(dfs_pkg::FUNC_SET, 27, 0, 1);
        push_cmd(dfs_pkg::FUNC_SET, 0, 27, 0);
        push_cmd(dfs_pkg::FUNC_SET, 28, 3, 1);
        push_cmd(dfs_pkg::FUNC_SET, 3, 28, 0);
        // sweep undoes the direct set since target is still clear
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);
        // leave the cursor mid-sweep before switching the order
        push_cmd(dfs_pkg::FUNC_LOAD, 3, 4, 1);
        push_cmd(dfs_pkg::FUNC_LOAD, 10, 2, 1);
        push_cmd(dfs_pkg::FUNC_LOAD, 20, 16, 1);
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);

        // order changed mid-sweep: cursor number reread column-major, dots behind it wait
        set_order(1'b1);
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);
        push_cmd(dfs_pkg::FUNC_LOAD, 10, 2, 0);
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);
        push_cmd(dfs_pkg::FUNC_NEXT, 0, 0, 0);

        // random phases across both orders
        set_order(1'b0);
        queue_random(250);
        set_order(1'b1);
        queue_random(250);
        set_order(1'b0);
        queue_random(260);

        wait_quiet();
        repeat (TAIL_CYCS) @(negedge i_clk);
        if (fault_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
